### rtl/core/bdce_pkg.sv
// ----------------------------------------------------------------------------
// bdce_pkg
// shared types and constants for the bezier de casteljau engine
// ----------------------------------------------------------------------------
package bdce_pkg;

   // fixed field widths
   localparam int unsigned T_W      = 17;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned PIDX_W   = 3;
   localparam int unsigned SEQ_W    = 6;
   localparam int unsigned PCNT_W   = 4;
   localparam int unsigned IDX_MAX_W = 4;    // enough for the largest point store
   localparam logic [T_W-1:0] T_ONE = 17'd65536;
   localparam logic [SEQ_W-1:0] SEQ_LAST = 6'd63;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_EVAL = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_SPLIT = 2'd3
   } op_type;

   // register indexes
   localparam logic REG_POINT_COUNT = 1'b0;
   localparam logic REG_T_STEP      = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_RIGHT = 4'b1000
   } state_type;

   // controls shared by all coordinate lanes
   typedef struct packed {
      logic                 load_we;
      logic [IDX_MAX_W-1:0] load_idx;
      logic                 copy;
      logic                 shift;
      logic                 capture;
      logic [IDX_MAX_W-1:0] wr_pos;
      logic                 rx_we;
      logic [IDX_MAX_W-1:0] rx_widx;
      logic [IDX_MAX_W-1:0] rx_ridx;
      logic [T_W-1:0]       t;
   } lane_ctl_type;

   // result beat control toward the merge stage
   typedef struct packed {
      logic             valid;
      logic             right;
      logic [SEQ_W-1:0] seq;
      logic             last;
   } emit_type;

endpackage

### rtl/core/bdce_lane.sv
// ----------------------------------------------------------------------------
// bdce_lane
// one coordinate lane: point store, triangle shift line, lerp unit
// ----------------------------------------------------------------------------
module bdce_lane #(
   parameter int unsigned MAX_POINTS = 8,
   parameter int unsigned COORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bdce_pkg::lane_ctl_type      ctl,
   input  logic signed [31:0]          load_val,
   output logic signed [COORD_BITS-1:0] head,
   output logic signed [COORD_BITS-1:0] rx_val
);
   import bdce_pkg::*;

   localparam int unsigned IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

   logic signed [COORD_BITS-1:0]    store_ff [MAX_POINTS];
   logic signed [COORD_BITS-1:0]    w_ff     [MAX_POINTS];
   logic signed [COORD_BITS-1:0]    rx_ff    [MAX_POINTS];
   logic signed [COORD_BITS-1:0]    a_ff;
   logic signed [COORD_BITS+18:0]   prod_ff;
   logic signed [COORD_BITS+18:0]   prod_in;
   logic signed [COORD_BITS:0]      diff;
   logic signed [COORD_BITS-1:0]    res;
   logic signed [COORD_BITS-1:0]    load_coord;
   logic signed [63:0]              load_ext;
   logic                            wr_vld_ff;

   // loaded coordinate kept in COORD_BITS, two's complement
   assign load_ext   = {{32{load_val[31]}}, load_val};
   assign load_coord = load_ext[COORD_BITS-1:0];

   // lerp: a + floor((b - a) * t / 65536)
   assign diff    = {w_ff[1][COORD_BITS-1], w_ff[1]} - {w_ff[0][COORD_BITS-1], w_ff[0]};
   assign prod_in = diff * $signed({1'b0, ctl.t});
   assign res     = a_ff + prod_ff[COORD_BITS+15:16];

   assign head   = w_ff[0];
   assign rx_val = rx_ff[ctl.rx_ridx[IDX_W-1:0]];

   // control point store, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_POINTS; j++) store_ff[j] <= '0;
      end else if (ctl.load_we) begin
         store_ff[ctl.load_idx[IDX_W-1:0]] <= load_coord;
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= ctl.capture;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         a_ff    <= w_ff[0];
         prod_ff <= prod_in;
      end
   end

   // triangle shift line, results land at the level's tail
   always_ff @(posedge clock) begin
      if (ctl.copy) begin
         for (int j = 0; j < MAX_POINTS; j++) w_ff[j] <= store_ff[j];
      end else if (ctl.shift) begin
         for (int j = 0; j < MAX_POINTS - 1; j++) w_ff[j] <= w_ff[j+1];
         if (wr_vld_ff) w_ff[ctl.wr_pos[IDX_W-1:0]] <= res;
      end
   end

   // right subcurve points, one per level
   always_ff @(posedge clock) begin
      if (ctl.rx_we) rx_ff[ctl.rx_widx[IDX_W-1:0]] <= w_ff[0];
   end

endmodule

### rtl/core/bdce_ctrl.sv
// ----------------------------------------------------------------------------
// bdce_ctrl
// sequencer: registers, triangle levels, sample stepping, subdivide order
// ----------------------------------------------------------------------------
module bdce_ctrl #(
   parameter int unsigned MAX_POINTS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bdce_pkg::OP_W-1:0]    req_op,
   input  logic [bdce_pkg::PIDX_W-1:0]  req_point_index,
   input  logic [bdce_pkg::T_W-1:0]     req_t_a,
   input  logic [bdce_pkg::T_W-1:0]     req_t_b,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [bdce_pkg::T_W-1:0]     csr_wdata,
   output bdce_pkg::lane_ctl_type       ctl,
   output bdce_pkg::emit_type           emit
);
   import bdce_pkg::*;

   localparam int unsigned IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [T_W:0]      t_ff, t_in, next_t;
   logic [T_W-1:0]    tb_ff, tb_in;
   logic [T_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]  n_ff, n_in, len_ff, len_in, cyc_ff, cyc_in, n_clamp;
   logic [IDX_W-1:0]  lv_ff, lv_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [PCNT_W-1:0] pcnt_ff;
   logic [T_W-1:0]    tstep_ff;
   logic [T_W-1:0]    ta_sat, tb_sat;
   logic              head_cyc, last_cyc, apex, run_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff  <= PCNT_W'(3);
         tstep_ff <= T_W'(6554);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POINT_COUNT: pcnt_ff  <= csr_wdata[PCNT_W-1:0];
            REG_T_STEP:      tstep_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   assign ta_sat = (req_t_a > T_ONE) ? T_ONE : req_t_a;
   assign tb_sat = (req_t_b > T_ONE) ? T_ONE : req_t_b;

   always_comb begin
      if (32'(pcnt_ff) < 2)               n_clamp = CNT_W'(2);
      else if (32'(pcnt_ff) > MAX_POINTS) n_clamp = CNT_W'(MAX_POINTS);
      else                                n_clamp = CNT_W'(pcnt_ff);
   end

   assign busy     = (state_ff != ST_IDLE);
   assign next_t   = t_ff + {1'b0, step_ff};
   assign head_cyc = (cyc_ff == '0);
   assign last_cyc = (cyc_ff == len_ff - CNT_W'(1));
   assign apex     = (len_ff == CNT_W'(1));
   assign run_last = (op_ff == OP_EVAL) || (next_t > {1'b0, tb_ff}) || (seq_ff == SEQ_LAST);

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      t_in     = t_ff;
      tb_in    = tb_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      len_in   = len_ff;
      cyc_in   = cyc_ff;
      lv_in    = lv_ff;
      seq_in   = seq_ff;
      ctl          = '0;
      ctl.load_idx = IDX_MAX_W'(req_point_index);
      ctl.wr_pos   = IDX_MAX_W'(len_ff - CNT_W'(2));
      ctl.rx_widx  = IDX_MAX_W'(lv_ff);
      ctl.rx_ridx  = IDX_MAX_W'(lv_ff);
      ctl.t        = t_ff[T_W-1:0];
      emit     = '0;
      emit.seq = seq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = op_type'(req_op);
               t_in    = {1'b0, ta_sat};
               tb_in   = tb_sat;
               step_in = (tstep_ff == '0) ? T_W'(1) : tstep_ff;
               n_in    = n_clamp;
               seq_in  = '0;
               priority if (op_type'(req_op) == OP_LOAD) begin
                  ctl.load_we = (32'(req_point_index) < MAX_POINTS);
               end else if (op_type'(req_op) == OP_SAMPLE && ta_sat > tb_sat) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            ctl.copy = 1'b1;
            len_in   = n_ff;
            cyc_in   = '0;
            lv_in    = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            ctl.shift   = 1'b1;
            ctl.capture = (cyc_ff < len_ff - CNT_W'(1));
            // result beats
            if (op_ff == OP_SPLIT) begin
               emit.valid = head_cyc;
               ctl.rx_we  = last_cyc;
            end else begin
               emit.valid = apex;
               emit.last  = run_last;
            end
            if (emit.valid) seq_in = seq_ff + SEQ_W'(1);
            // level and sample advance
            if (last_cyc) begin
               if (apex) begin
                  priority if (op_ff == OP_SPLIT) begin
                     lv_in    = IDX_W'(n_ff - CNT_W'(1));
                     state_in = ST_RIGHT;
                  end else if (run_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     t_in     = next_t;
                     state_in = ST_LOAD;
                  end
               end else begin
                  len_in = len_ff - CNT_W'(1);
                  cyc_in = '0;
                  lv_in  = lv_ff + IDX_W'(1);
               end
            end else begin
               cyc_in = cyc_ff + CNT_W'(1);
            end
         end
         ST_RIGHT: begin
            emit.valid = 1'b1;
            emit.right = 1'b1;
            emit.last  = (lv_ff == '0);
            seq_in     = seq_ff + SEQ_W'(1);
            lv_in      = lv_ff - IDX_W'(1);
            if (lv_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      t_ff    <= t_in;
      tb_ff   <= tb_in;
      step_ff <= step_in;
      n_ff    <= n_in;
      len_ff  <= len_in;
      cyc_ff  <= cyc_in;
      lv_ff   <= lv_in;
      seq_ff  <= seq_in;
   end

endmodule

### rtl/core/bdce_merge.sv
// ----------------------------------------------------------------------------
// bdce_merge
// merge stage: picks each lane's point and registers the result beat
// ----------------------------------------------------------------------------
module bdce_merge #(
   parameter int unsigned COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bdce_pkg::emit_type            emit,
   input  logic signed [COORD_BITS-1:0]  head_x,
   input  logic signed [COORD_BITS-1:0]  head_y,
   input  logic signed [COORD_BITS-1:0]  head_z,
   input  logic signed [COORD_BITS-1:0]  rx_x,
   input  logic signed [COORD_BITS-1:0]  rx_y,
   input  logic signed [COORD_BITS-1:0]  rx_z,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_out_z,
   output logic                          rsp_half,
   output logic [bdce_pkg::SEQ_W-1:0]    rsp_seq,
   output logic                          rsp_last
);
   import bdce_pkg::*;

   logic signed [COORD_BITS-1:0] sx, sy, sz;
   logic signed [63:0]           ex, ey, ez;

   // select the lane source, then fit to 32 bits
   assign sx = emit.right ? rx_x : head_x;
   assign sy = emit.right ? rx_y : head_y;
   assign sz = emit.right ? rx_z : head_z;
   assign ex = {{(64-COORD_BITS){sx[COORD_BITS-1]}}, sx};
   assign ey = {{(64-COORD_BITS){sy[COORD_BITS-1]}}, sy};
   assign ez = {{(64-COORD_BITS){sz[COORD_BITS-1]}}, sz};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_x <= ex[31:0];
      rsp_out_y <= ey[31:0];
      rsp_out_z <= ez[31:0];
      rsp_half  <= emit.right;
      rsp_seq   <= emit.seq;
      rsp_last  <= emit.last;
   end

endmodule

### rtl/core/bezier_de_casteljau_engine_unit.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_engine_unit
// de casteljau bezier evaluation, range sampling and subdivision
// ----------------------------------------------------------------------------
//  channel   | ports                              | beat taken when
//  request   | start, busy, req_*                 | start && !busy
//  response  | rsp_valid, rsp_*                   | rsp_valid, one cycle
//  config    | csr_we, csr_index, csr_wdata       | csr_we
//
//  one point (n = clamped point count) is a copy from the store, then the lerps
//  of each coordinate lane through the levels of the triangle
//  a subdivide then emits the n right subcurve points; a load writes one point
//  the result leaves in the cycle after it is formed; the receiver cannot stall
//  reset clears the point store at once; no clearing pass
// ----------------------------------------------------------------------------
module bezier_de_casteljau_engine_unit #(
   parameter int unsigned MAX_POINTS = 8,
   parameter int unsigned COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bdce_pkg::OP_W-1:0]    req_op,
   input  logic [bdce_pkg::PIDX_W-1:0]  req_point_index,
   input  logic signed [31:0]           req_in_x,
   input  logic signed [31:0]           req_in_y,
   input  logic signed [31:0]           req_in_z,
   input  logic [bdce_pkg::T_W-1:0]     req_t_a,
   input  logic [bdce_pkg::T_W-1:0]     req_t_b,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [bdce_pkg::T_W-1:0]     csr_wdata,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_out_x,
   output logic signed [31:0]           rsp_out_y,
   output logic signed [31:0]           rsp_out_z,
   output logic                         rsp_half,
   output logic [bdce_pkg::SEQ_W-1:0]   rsp_seq,
   output logic                         rsp_last
);
   import bdce_pkg::*;

   lane_ctl_type                 ctl;
   emit_type                     emit;
   logic signed [COORD_BITS-1:0] head_x, head_y, head_z, rx_x, rx_y, rx_z;

   // sequencer
   bdce_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_point_index(req_point_index),
      .req_t_a(req_t_a), .req_t_b(req_t_b),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .ctl(ctl), .emit(emit)
   );

   // coordinate lanes
   bdce_lane #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_lane_x (
      .clock(clock), .reset(reset), .ctl(ctl), .load_val(req_in_x),
      .head(head_x), .rx_val(rx_x)
   );
   bdce_lane #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_lane_y (
      .clock(clock), .reset(reset), .ctl(ctl), .load_val(req_in_y),
      .head(head_y), .rx_val(rx_y)
   );
   bdce_lane #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_lane_z (
      .clock(clock), .reset(reset), .ctl(ctl), .load_val(req_in_z),
      .head(head_z), .rx_val(rx_z)
   );

   // merge and output register
   bdce_merge #(.COORD_BITS(COORD_BITS)) u_merge (
      .clock(clock), .reset(reset), .emit(emit),
      .head_x(head_x), .head_y(head_y), .head_z(head_z),
      .rx_x(rx_x), .rx_y(rx_y), .rx_z(rx_z),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_half(rsp_half), .rsp_seq(rsp_seq),
      .rsp_last(rsp_last)
   );

endmodule
